### design/nnnh_pkg.sv
// Shared types and constants for the nearest-neighbor next-hop block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package nnnh_pkg;

   localparam int POS_W  = 20;
   localparam int ADDR_W = 8;
   localparam int DIST_W = 42;   // sum of three squares of 21-bit magnitudes
   localparam int RSQ_W  = 40;   // square of the 20-bit range

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_ROUTE = 1'b1;

   localparam logic [2:0] STAT_ADDED    = 3'd0;
   localparam logic [2:0] STAT_REJECTED = 3'd1;
   localparam logic [2:0] STAT_UP       = 3'd2;
   localparam logic [2:0] STAT_FORWARD  = 3'd3;
   localparam logic [2:0] STAT_NO_HOP   = 3'd4;
   localparam logic [2:0] STAT_UNSET    = 3'd5;

   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_MAX_RANGE   = 1'b1;

   localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 8'd0;
   localparam logic [POS_W-1:0]  MAX_RANGE_RESET   = 20'd3000;
   localparam logic [RSQ_W-1:0]  RANGE_SQ_RESET    = 40'd9000000;

   typedef struct packed {
      logic                     action;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [ADDR_W-1:0]        neighbor_addr;
      logic [ADDR_W-1:0]        dest_addr;
      logic                     going_up;
   } req_word_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] hop_addr;
   } rsp_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [ADDR_W-1:0]       addr;
   } entry_type;

   typedef struct packed {
      logic              found;
      logic [DIST_W-1:0] dist_sq;
      logic [ADDR_W-1:0] addr;
   } best_type;

   // Token handed from cell to cell: the previous cell's candidate is folded
   // into the running best by the next cell, one register later.
   typedef struct packed {
      logic              valid;
      logic              cand_live;
      logic [DIST_W-1:0] cand_dist;
      logic [ADDR_W-1:0] cand_addr;
      best_type          best;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_JUDGE,
      ST_DONE
   } state_type;

   // Strict less-than keeps the earlier entry on a tie.
   function automatic best_type fold_best(token_type t);
      best_type b;
      b = t.best;
      if (t.cand_live && (!t.best.found || (t.cand_dist < t.best.dist_sq))) begin
         b.found   = 1'b1;
         b.dist_sq = t.cand_dist;
         b.addr    = t.cand_addr;
      end
      return b;
   endfunction

endpackage

### design/nearest_neighbor_next_hop.sv
// Top level of the nearest-neighbor next-hop selector: control, registers,
// result stage and the chain of nnnh_cell instances. Depends on nnnh_pkg.
//
//   port group | direction | carries
//   req_*      | in        | one request word: add entry or route packet
//   rsp_*      | out       | one response word: status and next hop
//   csr_*      | in        | register writes: own address, max range
//
// An add or an early decision (address unset, delivered up) goes through the
// result register to the response register; a routed packet walks the token one
// cell per cycle down the chain, then passes the final-best, result and response registers.
// One request is in flight at a time; a waiting response does not block the
// next request from being accepted. Reset is synchronous and clears the table
// fill count and the registers to their defaults; rsp_stall only holds the
// response word and the final handoff.
`timescale 1ns / 1ps

module nearest_neighbor_next_hop
   import nnnh_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_data,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [POS_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_NEIGHBORS + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [ADDR_W-1:0] own_addr_ff;
   logic [POS_W-1:0] max_range_ff;
   logic [RSQ_W-1:0] range_sq_ff;
   logic signed [POS_W-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic start_ff;
   best_type fin_ff;
   rsp_word_type res_ff, res_in;
   logic res_we;
   logic rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   logic req_take, add_ok, go_walk, fin_we, rsp_load, slot_free, full;

   token_type tok [0:MAX_NEIGHBORS];
   entry_type wr_entry;
   logic [MAX_NEIGHBORS-1:0] live;
   logic [MAX_NEIGHBORS-1:0] cell_we;
   logic [MAX_NEIGHBORS-1:0] tok_valids;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign full      = (count_ff == CW'(MAX_NEIGHBORS));
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      res_we   = 1'b0;
      add_ok   = 1'b0;
      go_walk  = 1'b0;
      fin_we   = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_in.hop_addr = '0;
               res_we          = 1'b1;
               if (req_data.action == ACT_ADD) begin
                  add_ok        = (req_data.neighbor_addr != '0) && !full;
                  res_in.status = add_ok ? STAT_ADDED : STAT_REJECTED;
                  state_in      = ST_DONE;
               end else if (own_addr_ff == '0) begin
                  res_in.status = STAT_UNSET;
                  state_in      = ST_DONE;
               end else if (req_data.going_up && (req_data.dest_addr == own_addr_ff)) begin
                  res_in.status = STAT_UP;
                  state_in      = ST_DONE;
               end else begin
                  res_we   = 1'b0;
                  go_walk  = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (tok[MAX_NEIGHBORS].valid) begin
               fin_we   = 1'b1;
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            res_we = 1'b1;
            if (fin_ff.found && (fin_ff.dist_sq < DIST_W'(range_sq_ff))) begin
               res_in.status   = STAT_FORWARD;
               res_in.hop_addr = fin_ff.addr;
            end else begin
               res_in.status   = STAT_NO_HOP;
               res_in.hop_addr = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_addr_ff  <= OWN_ADDRESS_RESET;
         max_range_ff <= MAX_RANGE_RESET;
         range_sq_ff  <= RANGE_SQ_RESET;
      end else begin
         if (add_ok) begin
            count_ff <= count_ff + CW'(1);
         end
         start_ff <= go_walk;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en && (csr_index == CSR_OWN_ADDRESS)) begin
            own_addr_ff <= csr_wdata[ADDR_W-1:0];
         end
         // A zero range is not a legal setting and leaves the old value.
         if (csr_wr_en && (csr_index == CSR_MAX_RANGE) && (csr_wdata != '0)) begin
            max_range_ff <= csr_wdata;
         end
         range_sq_ff <= RSQ_W'(max_range_ff) * RSQ_W'(max_range_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (go_walk) begin
         q_x_ff <= req_data.pos_x;
         q_y_ff <= req_data.pos_y;
         q_z_ff <= req_data.pos_z;
      end
      if (fin_we) begin
         fin_ff <= fold_best(tok[MAX_NEIGHBORS]);
      end
      if (res_we) begin
         res_ff <= res_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wr_entry.x    = req_data.pos_x;
   assign wr_entry.y    = req_data.pos_y;
   assign wr_entry.z    = req_data.pos_z;
   assign wr_entry.addr = req_data.neighbor_addr;

   // The head of the chain carries only the start flag; valid is the top field.
   assign tok[0] = token_type'({start_ff, ($bits(token_type) - 1)'(0)});

   genvar gi;
   generate
      for (gi = 0; gi < MAX_NEIGHBORS; gi++) begin : g_cell
         assign live[gi]       = (CW'(gi) < count_ff);
         assign cell_we[gi]    = add_ok && (count_ff == CW'(gi));
         assign tok_valids[gi] = tok[gi+1].valid;

         nnnh_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .wr_en    (cell_we[gi]),
            .wr_entry (wr_entry),
            .live     (live[gi]),
            .q_x      (q_x_ff),
            .q_y      (q_y_ff),
            .q_z      (q_z_ff),
            .tok_in   (tok[gi]),
            .tok_out  (tok[gi+1])
         );
      end
   endgenerate

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NEIGHBORS))
      else $error("table fill count beyond capacity");

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones({start_ff, tok_valids}) <= 1)
      else $error("more than one token in the neighbor chain");

   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_NEIGHBORS].valid |-> state_ff == ST_WALK)
      else $error("chain token emerged outside the walk");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      add_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted add did not grow the table");

   a_forward_hop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == STAT_FORWARD)) |-> rsp_data_ff.hop_addr != '0)
      else $error("forwarded word carries a zero next hop");

endmodule

### design/nnnh_cell.sv
// One neighbor cell of the chain: holds one table entry and folds the
// token passing through it. Depends on nnnh_pkg.
`timescale 1ns / 1ps

module nnnh_cell
   import nnnh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  entry_type               wr_entry,
   input  logic                    live,
   input  logic signed [POS_W-1:0] q_x,
   input  logic signed [POS_W-1:0] q_y,
   input  logic signed [POS_W-1:0] q_z,
   input  token_type               tok_in,
   output token_type               tok_out
);

   entry_type entry_ff;
   token_type tok_ff;
   token_type tok_in_next;

   logic signed [POS_W:0] dx, dy, dz;
   logic [POS_W:0]        mx, my, mz;
   logic [DIST_W-1:0]     sx, sy, sz;

   always_comb begin
      dx = {entry_ff.x[POS_W-1], entry_ff.x} - {q_x[POS_W-1], q_x};
      dy = {entry_ff.y[POS_W-1], entry_ff.y} - {q_y[POS_W-1], q_y};
      dz = {entry_ff.z[POS_W-1], entry_ff.z} - {q_z[POS_W-1], q_z};
      mx = dx[POS_W] ? (POS_W+1)'(0) - dx : dx;
      my = dy[POS_W] ? (POS_W+1)'(0) - dy : dy;
      mz = dz[POS_W] ? (POS_W+1)'(0) - dz : dz;
      sx = DIST_W'(mx) * DIST_W'(mx);
      sy = DIST_W'(my) * DIST_W'(my);
      sz = DIST_W'(mz) * DIST_W'(mz);

      tok_in_next.valid     = tok_in.valid;
      tok_in_next.best      = fold_best(tok_in);
      tok_in_next.cand_live = live;
      tok_in_next.cand_dist = sx + sy + sz;
      tok_in_next.cand_addr = entry_ff.addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.cand_live <= tok_in_next.cand_live;
      tok_ff.cand_dist <= tok_in_next.cand_dist;
      tok_ff.cand_addr <= tok_in_next.cand_addr;
      tok_ff.best      <= tok_in_next.best;
   end

   assign tok_out = tok_ff;

endmodule

### verif/nearest_neighbor_next_hop_tb.sv
// Self-checking testbench for nearest_neighbor_next_hop: directed and random
// add/route words, with its own next-hop predictor. Depends on nnnh_pkg.
`timescale 1ns / 1ps

module nearest_neighbor_next_hop_tb;
   import nnnh_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 100;
   localparam longint FAR_LIMIT_SQ = 64'd100_000_000_000_000;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_OWN_ADDRESS;
   logic [POS_W-1:0] csr_wdata = '0;

   // Predictor copy of the neighbor table and registers.
   logic signed [POS_W-1:0] nbr_x [TABLE_DEPTH];
   logic signed [POS_W-1:0] nbr_y [TABLE_DEPTH];
   logic signed [POS_W-1:0] nbr_z [TABLE_DEPTH];
   logic [ADDR_W-1:0] nbr_addr [TABLE_DEPTH];
   int nbr_count = 0;
   logic [ADDR_W-1:0] cfg_own_addr = OWN_ADDRESS_RESET;
   logic [POS_W-1:0] cfg_range = MAX_RANGE_RESET;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int words_accepted = 0;
   int fail_count = 0;
   int status_count [8];
   int burst_left = 0;
   int gap_left = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   nearest_neighbor_next_hop #(
      .MAX_NEIGHBORS(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one word to the predicted table and returns the expected response.
   function automatic rsp_word_type predict_route(req_word_type w);
      rsp_word_type r;
      logic signed [POS_W-1:0] px, py, pz;
      longint dx, dy, dz, d, best_dist, range_sq;
      logic [ADDR_W-1:0] best_addr;
      r.status = STAT_NO_HOP;
      r.hop_addr = '0;
      px = w.pos_x;
      py = w.pos_y;
      pz = w.pos_z;
      if (w.action == ACT_ADD) begin
         if (w.neighbor_addr == '0 || nbr_count >= TABLE_DEPTH) begin
            r.status = STAT_REJECTED;
         end else begin
            nbr_x[nbr_count] = px;
            nbr_y[nbr_count] = py;
            nbr_z[nbr_count] = pz;
            nbr_addr[nbr_count] = w.neighbor_addr;
            nbr_count++;
            r.status = STAT_ADDED;
         end
      end else if (cfg_own_addr == '0) begin
         r.status = STAT_UNSET;
      end else if (w.going_up && w.dest_addr == cfg_own_addr) begin
         r.status = STAT_UP;
      end else begin
         best_dist = FAR_LIMIT_SQ;
         best_addr = '0;
         range_sq = longint'(cfg_range) * longint'(cfg_range);
         for (int i = 0; i < nbr_count; i++) begin
            dx = longint'(nbr_x[i]) - longint'(px);
            dy = longint'(nbr_y[i]) - longint'(py);
            dz = longint'(nbr_z[i]) - longint'(pz);
            d = dx * dx + dy * dy + dz * dz;
            // Strictly closer only, so the earlier entry keeps a tie.
            if (d < best_dist) begin
               best_dist = d;
               best_addr = nbr_addr[i];
            end
         end
         if (best_addr != '0 && best_dist < range_sq) begin
            r.status = STAT_FORWARD;
            r.hop_addr = best_addr;
         end
      end
      return r;
   endfunction

   function automatic void enqueue_word(req_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic req_word_type add_word(logic [ADDR_W-1:0] addr, int x, int y, int z);
      req_word_type w;
      w.action = ACT_ADD;
      w.pos_x = POS_W'(x);
      w.pos_y = POS_W'(y);
      w.pos_z = POS_W'(z);
      w.neighbor_addr = addr;
      w.dest_addr = ADDR_W'($urandom);
      w.going_up = 1'($urandom);
      return w;
   endfunction

   function automatic req_word_type route_word(int x, int y, int z,
                                               logic [ADDR_W-1:0] dest, logic up);
      req_word_type w;
      w.action = ACT_ROUTE;
      w.pos_x = POS_W'(x);
      w.pos_y = POS_W'(y);
      w.pos_z = POS_W'(z);
      w.neighbor_addr = ADDR_W'($urandom);
      w.dest_addr = dest;
      w.going_up = up;
      return w;
   endfunction

   function automatic int jitter(int k);
      return int'($urandom_range(0, 2 * k)) - k;
   endfunction

   // Sender: bursts of random length separated by random gaps. A word that is
   // offered stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.insert(expected_rsp.size(), predict_route(req_data));
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each response word and stalls in modes of random length,
   // plus long holds on request.
   always @(posedge clock) begin : response_monitor
      rsp_word_type want;
      logic stall_now;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         mode_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response with nothing outstanding: status %0d hop_addr %0d",
                      rsp_data.status, rsp_data.hop_addr);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.hop_addr !== want.hop_addr) begin
                  $error("hop_addr: expected %0d, got %0d", want.hop_addr, rsp_data.hop_addr);
                  fail_count++;
               end
            end
            if (!$isunknown(rsp_data.status)) begin
               status_count[rsp_data.status]++;
            end
         end
         if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 150);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: stall_now = 1'b0;
            1: stall_now = ($urandom_range(0, 3) == 0);
            default: stall_now = ($urandom_range(0, 3) != 0);
         endcase
         rsp_stall <= stall_now || (hold_left > 1) || (hold_seen != hold_asks);
      end
   end

   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
   endtask

   task automatic write_csr(logic idx, logic [POS_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_OWN_ADDRESS) begin
         cfg_own_addr = value[ADDR_W-1:0];
      end else if (value != '0) begin
         // A zero range is ignored by the block.
         cfg_range = value;
      end
   endtask

   task automatic queue_random_words(int count);
      int pick, k, a;
      logic [ADDR_W-1:0] addr;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         k = (int'(cfg_range) * 3) / 4 + 1;
         a = (nbr_count > 0) ? $urandom_range(0, nbr_count - 1) : 0;
         if (pick < 20) begin
            addr = ($urandom_range(0, 7) == 0) ? '0 : ADDR_W'($urandom_range(1, 255));
            if (nbr_count > 0 && $urandom_range(0, 1) == 1) begin
               enqueue_word(add_word(addr, nbr_x[a] + jitter(2000),
                                     nbr_y[a] + jitter(2000),
                                     nbr_z[a] + jitter(2000)));
            end else begin
               enqueue_word(add_word(addr, $urandom, $urandom, $urandom));
            end
         end else if (pick < 30) begin
            enqueue_word(route_word($urandom, $urandom, $urandom, cfg_own_addr, 1'b1));
         end else if (pick < 80 && nbr_count > 0) begin
            // Near a stored neighbor, so the range check goes either way.
            enqueue_word(route_word(nbr_x[a] + jitter(k), nbr_y[a] + jitter(k),
                                    nbr_z[a] + jitter(k), ADDR_W'($urandom),
                                    1'($urandom)));
         end else begin
            enqueue_word(route_word($urandom, $urandom, $urandom,
                                    ADDR_W'($urandom), 1'($urandom)));
         end
      end
   endtask

   initial begin
      logic [POS_W-1:0] range_val;
      logic [ADDR_W-1:0] own_val;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Own address still unset after reset: packets drop; an add with address zero is rejected.
      @(negedge clock);
      enqueue_word(route_word(10, 20, 30, 8'h5A, 1'b0));
      enqueue_word(add_word(8'd0, 1, 2, 3));
      wait_until_drained();
      write_csr(CSR_OWN_ADDRESS, 20'h0005A);

      @(negedge clock);
      enqueue_word(route_word(0, 0, 0, 8'h33, 1'b0));
      enqueue_word(route_word(5, 5, 5, 8'h5A, 1'b1));
      enqueue_word(route_word(5, 5, 5, 8'h5A, 1'b0));
      enqueue_word(add_word(8'd255, 524287, 524287, 524287));
      enqueue_word(add_word(8'd1, -524288, -524288, -524288));
      enqueue_word(route_word(-524288, -524288, -524288, 8'h33, 1'b0));
      enqueue_word(route_word(524287, 524287, 524287, 8'h33, 1'b1));
      enqueue_word(add_word(8'h10, 100, 200, -300));
      enqueue_word(add_word(8'h11, 100, 200, -300));
      enqueue_word(route_word(100, 200, -300, 8'h33, 1'b0));
      // Reset range of 3000: just inside, then exactly on the boundary.
      enqueue_word(route_word(3099, 200, -300, 8'h33, 1'b0));
      enqueue_word(route_word(3100, 200, -300, 8'h33, 1'b0));
      enqueue_word(route_word(100, 200, 2699, 8'h5A, 1'b0));
      wait_until_drained();

      write_csr(CSR_MAX_RANGE, 20'd1);
      @(negedge clock);
      enqueue_word(route_word(100, 200, -300, 8'h33, 1'b0));
      enqueue_word(route_word(101, 200, -300, 8'h33, 1'b0));
      wait_until_drained();
      write_csr(CSR_MAX_RANGE, 20'd0);
      @(negedge clock);
      enqueue_word(route_word(101, 200, -300, 8'h33, 1'b0));
      wait_until_drained();
      write_csr(CSR_MAX_RANGE, 20'hFFFFF);
      @(negedge clock);
      enqueue_word(route_word(0, 0, 0, 8'h33, 1'b0));
      enqueue_word(route_word(524287, -524288, 0, 8'h33, 1'b1));
      wait_until_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 6)
            0: range_val = 20'd1;
            1: range_val = 20'hFFFFF;
            2: range_val = 20'd0;
            3: range_val = POS_W'($urandom_range(1, 4000));
            4: range_val = POS_W'($urandom_range(1, 20'hFFFFF));
            default: range_val = POS_W'($urandom_range(1000, 100000));
         endcase
         if (p % 5 == 4) begin
            own_val = '0;
         end else if (p % 5 == 3) begin
            own_val = 8'hFF;
         end else begin
            own_val = ADDR_W'($urandom_range(1, 255));
         end
         write_csr(CSR_OWN_ADDRESS, {12'($urandom), own_val});
         write_csr(CSR_MAX_RANGE, range_val);
         @(negedge clock);
         queue_random_words(WORDS_PER_PHASE);
         if (p == 2 || p == 7) begin
            hold_asks++;
         end
         wait_until_drained();
      end

      repeat (TABLE_DEPTH + 8) @(posedge clock);
      $display("Covered %0d words in %0d register settings, table filled to %0d entries.",
               words_accepted, RANDOM_PHASES + 5, nbr_count);
      $display("Responses: %0d added, %0d rejected, %0d up, %0d forwarded, %0d no hop, %0d unset.",
               status_count[STAT_ADDED], status_count[STAT_REJECTED], status_count[STAT_UP],
               status_count[STAT_FORWARD], status_count[STAT_NO_HOP], status_count[STAT_UNSET]);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Run timed out with %0d responses outstanding.", expected_rsp.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
design/nnnh_pkg.sv
design/nnnh_cell.sv
design/nearest_neighbor_next_hop.sv
verif/nearest_neighbor_next_hop_tb.sv
